@@ hw/rtl/bw_pkg.sv @@
// ----------------------------------------------------------------------------
// bw_pkg
// Widths and shared types of the barycentric weights unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bw_pkg;

	localparam int CRD_W   = 24;            // input coordinate
	localparam int DIFF_W  = CRD_W + 1;     // edge vector component
	localparam int EPROD_W = 2 * DIFF_W;    // component product
	localparam int DOT_W   = EPROD_W + 1;   // dot product, signed
	localparam int MAG_W   = DOT_W - 1;     // dot product magnitude
	localparam int HALF_W  = MAG_W / 2;     // multiplier split
	localparam int PROD_W  = 2 * MAG_W;     // product of two dot magnitudes
	localparam int SPROD_W = PROD_W + 1;    // signed product
	localparam int NUM_W   = SPROD_W + 1;   // signed numerator
	localparam int NMAG_W  = NUM_W - 1;     // numerator magnitude
	localparam int DEN_W   = PROD_W;        // denominator, never negative
	localparam int WT_W    = 32;            // output weight

	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	typedef struct packed {
		logic deg;
		logic neg_v;
		logic neg_w;
	} bw_side_t;

	typedef struct packed {
		logic signed [WT_W-1:0] u;
		logic signed [WT_W-1:0] v;
		logic signed [WT_W-1:0] w;
		logic                   deg;
	} bw_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/bw_if.sv @@
// ----------------------------------------------------------------------------
// bw_if
// Valid/ready channels of the barycentric weights unit: query and weights.
// ----------------------------------------------------------------------------
`default_nettype none

interface bw_query_if;
	logic                             valid;
	logic                             ready;
	logic signed [bw_pkg::CRD_W-1:0]  point_x;
	logic signed [bw_pkg::CRD_W-1:0]  point_y;
	logic signed [bw_pkg::CRD_W-1:0]  point_z;
	logic signed [bw_pkg::CRD_W-1:0]  corner0_x;
	logic signed [bw_pkg::CRD_W-1:0]  corner0_y;
	logic signed [bw_pkg::CRD_W-1:0]  corner0_z;
	logic signed [bw_pkg::CRD_W-1:0]  corner1_x;
	logic signed [bw_pkg::CRD_W-1:0]  corner1_y;
	logic signed [bw_pkg::CRD_W-1:0]  corner1_z;
	logic signed [bw_pkg::CRD_W-1:0]  corner2_x;
	logic signed [bw_pkg::CRD_W-1:0]  corner2_y;
	logic signed [bw_pkg::CRD_W-1:0]  corner2_z;

	modport source (
		output valid, point_x, point_y, point_z,
		output corner0_x, corner0_y, corner0_z,
		output corner1_x, corner1_y, corner1_z,
		output corner2_x, corner2_y, corner2_z,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z,
		input  corner0_x, corner0_y, corner0_z,
		input  corner1_x, corner1_y, corner1_z,
		input  corner2_x, corner2_y, corner2_z,
		output ready
	);
endinterface

interface bw_weights_if;
	logic                             valid;
	logic                             ready;
	logic signed [bw_pkg::WT_W-1:0]   weight_u;
	logic signed [bw_pkg::WT_W-1:0]   weight_v;
	logic signed [bw_pkg::WT_W-1:0]   weight_w;
	logic                             degenerate;

	modport source (
		output valid, weight_u, weight_v, weight_w, degenerate,
		input  ready
	);
	modport sink (
		input  valid, weight_u, weight_v, weight_w, degenerate,
		output ready
	);
endinterface

`default_nettype wire

@@ hw/rtl/bw_mul.sv @@
// ----------------------------------------------------------------------------
// bw_mul
// Two-stage unsigned multiplier for dot product magnitudes, built from four
// half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module bw_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [bw_pkg::MAG_W-1:0]    a,
	input  logic [bw_pkg::MAG_W-1:0]    b,
	output logic [bw_pkg::PROD_W-1:0]   prod
);

	localparam int H  = bw_pkg::HALF_W;
	localparam int M  = bw_pkg::MAG_W;
	localparam int PW = bw_pkg::PROD_W;

	logic [2*H-1:0] hh_s1, hl_s1, lh_s1, ll_s1;
	logic [PW-1:0]  prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= a[M-1:H] * b[M-1:H];
			hl_s1 <= a[M-1:H] * b[H-1:0];
			lh_s1 <= a[H-1:0] * b[M-1:H];
			ll_s1 <= a[H-1:0] * b[H-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (PW'(hh_s1) << (2 * H)) + (PW'(hl_s1) << H)
				+ (PW'(lh_s1) << H) + PW'(ll_s1);
		end
	end

	assign prod = prod_s2;

endmodule

`default_nettype wire

@@ hw/rtl/bw_div.sv @@
// ----------------------------------------------------------------------------
// bw_div
// Pipelined restoring divider: two numerator magnitudes over one shared
// denominator, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bw_div #(
	parameter int QW = bw_pkg::NMAG_W + bw_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [bw_pkg::DEN_W-1:0]    den,
	input  logic [bw_pkg::NMAG_W-1:0]   num_v,
	input  logic [bw_pkg::NMAG_W-1:0]   num_w,
	input  bw_pkg::bw_side_t            side_in,
	output logic                        out_valid,
	output logic [QW-1:0]               quo_v,
	output logic [QW-1:0]               quo_w,
	output bw_pkg::bw_side_t            side_out
);

	localparam int DW = bw_pkg::DEN_W;
	localparam int NW = bw_pkg::NMAG_W;

	// index 0 is the stage input, index i+1 the register after stage i
	logic             vld_q  [QW+1];
	logic [DW-1:0]    den_q  [QW+1];
	logic [DW-1:0]    rem_v_q[QW+1];
	logic [DW-1:0]    rem_w_q[QW+1];
	logic [QW-1:0]    qd_v_q [QW+1];
	logic [QW-1:0]    qd_w_q [QW+1];
	bw_pkg::bw_side_t sd_q   [QW+1];

	// numerator is pre-scaled by the weight fraction bits
	assign vld_q[0]   = in_valid;
	assign den_q[0]   = den;
	assign rem_v_q[0] = '0;
	assign rem_w_q[0] = '0;
	assign qd_v_q[0]  = {num_v, {(QW-NW){1'b0}}};
	assign qd_w_q[0]  = {num_w, {(QW-NW){1'b0}}};
	assign sd_q[0]    = side_in;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0]   tv, tw;
		logic [DW+1:0] dv, dw;

		always_comb begin
			tv = {rem_v_q[i], qd_v_q[i][QW-1]};
			tw = {rem_w_q[i], qd_w_q[i][QW-1]};
			dv = {1'b0, tv} - {2'b00, den_q[i]};
			dw = {1'b0, tw} - {2'b00, den_q[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end

		// keep the shifted remainder on borrow, else take the difference
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[i+1]   <= den_q[i];
				sd_q[i+1]    <= sd_q[i];
				rem_v_q[i+1] <= dv[DW+1] ? tv[DW-1:0] : dv[DW-1:0];
				rem_w_q[i+1] <= dw[DW+1] ? tw[DW-1:0] : dw[DW-1:0];
				qd_v_q[i+1]  <= {qd_v_q[i][QW-2:0], ~dv[DW+1]};
				qd_w_q[i+1]  <= {qd_w_q[i][QW-2:0], ~dw[DW+1]};
			end
		end
	end

	assign out_valid = vld_q[QW];
	assign quo_v     = qd_v_q[QW];
	assign quo_w     = qd_w_q[QW];
	assign side_out  = sd_q[QW];

endmodule

`default_nettype wire

@@ hw/rtl/barycentric_weights_unit.sv @@
// ----------------------------------------------------------------------------
// barycentric_weights_unit
// Barycentric weights of a point in a triangle by the dot-product method,
// fully pipelined.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------------
//   query    | in  | point_x/y/z, corner0_x/y/z, corner1_x/y/z, corner2_x/y/z
//   weights  | out | weight_u, weight_v, weight_w, degenerate
//
// One query per cycle while the skid is empty. The divider resolves one
// quotient bit per stage.
// Reset clears only the valid bits; there is no state between queries.
// The output register has a one-entry skid behind it; while the skid is
// occupied the whole pipeline holds and query.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module barycentric_weights_unit #(
	parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	bw_query_if.sink        query,
	bw_weights_if.source    weights
);

	localparam int CW  = bw_pkg::CRD_W;
	localparam int DFW = bw_pkg::DIFF_W;
	localparam int EPW = bw_pkg::EPROD_W;
	localparam int DTW = bw_pkg::DOT_W;
	localparam int MW  = bw_pkg::MAG_W;
	localparam int PW  = bw_pkg::PROD_W;
	localparam int SPW = bw_pkg::SPROD_W;
	localparam int NUW = bw_pkg::NUM_W;
	localparam int NMW = bw_pkg::NMAG_W;
	localparam int DW  = bw_pkg::DEN_W;
	localparam int WW  = bw_pkg::WT_W;
	localparam int QW  = NMW + WEIGHT_FRAC_BITS;
	localparam int SW  = QW + 1;
	localparam int UW  = QW + 3;

	localparam logic signed [UW-1:0] ONE_W = {{(UW-1){1'b0}}, 1'b1} << WEIGHT_FRAC_BITS;

	logic adv;
	logic out_v_q, skid_v_q;
	bw_pkg::bw_res_t out_q, skid_q, res_d;

	assign adv         = !skid_v_q;
	assign query.ready = adv;

	// ---------------- stage 1: edge vectors ----------------
	logic signed [CW-1:0] pt[3], c0[3], c1[3], c2[3];
	assign pt[0] = query.point_x;
	assign pt[1] = query.point_y;
	assign pt[2] = query.point_z;
	assign c0[0] = query.corner0_x;
	assign c0[1] = query.corner0_y;
	assign c0[2] = query.corner0_z;
	assign c1[0] = query.corner1_x;
	assign c1[1] = query.corner1_y;
	assign c1[2] = query.corner1_z;
	assign c2[0] = query.corner2_x;
	assign c2[1] = query.corner2_y;
	assign c2[2] = query.corner2_z;

	logic                  v_s1;
	logic signed [DFW-1:0] e0_s1[3], e1_s1[3], e2_s1[3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				e0_s1[k] <= {c1[k][CW-1], c1[k]} - {c0[k][CW-1], c0[k]};
				e1_s1[k] <= {c2[k][CW-1], c2[k]} - {c0[k][CW-1], c0[k]};
				e2_s1[k] <= {pt[k][CW-1], pt[k]} - {c0[k][CW-1], c0[k]};
			end
		end
	end

	// ---------------- stage 2: component products ----------------
	// dot order: e0.e0, e0.e1, e1.e1, e2.e0, e2.e1
	logic                  v_s2;
	logic signed [EPW-1:0] pr_s2[5][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pr_s2[0][k] <= e0_s1[k] * e0_s1[k];
				pr_s2[1][k] <= e0_s1[k] * e1_s1[k];
				pr_s2[2][k] <= e1_s1[k] * e1_s1[k];
				pr_s2[3][k] <= e2_s1[k] * e0_s1[k];
				pr_s2[4][k] <= e2_s1[k] * e1_s1[k];
			end
		end
	end

	// ---------------- stage 3: dot products ----------------
	logic                  v_s3;
	logic signed [DTW-1:0] d_s3[5];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 5; j++) begin
				d_s3[j] <= {pr_s2[j][0][EPW-1], pr_s2[j][0]}
					+ {pr_s2[j][1][EPW-1], pr_s2[j][1]}
					+ {pr_s2[j][2][EPW-1], pr_s2[j][2]};
			end
		end
	end

	// ---------------- stage 4: sign and magnitude ----------------
	logic                  v_s4;
	logic [MW-1:0]         mag_s4[5];
	logic                  sgn_s4[5];
	logic signed [DTW-1:0] dneg[5];

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			dneg[j] = -d_s3[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 5; j++) begin
				sgn_s4[j] <= d_s3[j][DTW-1];
				mag_s4[j] <= d_s3[j][DTW-1] ? dneg[j][MW-1:0] : d_s3[j][MW-1:0];
			end
		end
	end

	// ---------------- stages 5-6: products of dots ----------------
	// den = d00*d11 - d01*d01, nv = d11*d20 - d01*d21, nw = d00*d21 - d01*d20
	logic          v_s5, v_s6;
	logic [5:0]    psg_s5, psg_s6;
	logic [PW-1:0] prod_s6[6];

	bw_mul u_mul0 (.clk(clk), .en(adv), .a(mag_s4[0]), .b(mag_s4[2]), .prod(prod_s6[0]));
	bw_mul u_mul1 (.clk(clk), .en(adv), .a(mag_s4[1]), .b(mag_s4[1]), .prod(prod_s6[1]));
	bw_mul u_mul2 (.clk(clk), .en(adv), .a(mag_s4[2]), .b(mag_s4[3]), .prod(prod_s6[2]));
	bw_mul u_mul3 (.clk(clk), .en(adv), .a(mag_s4[1]), .b(mag_s4[4]), .prod(prod_s6[3]));
	bw_mul u_mul4 (.clk(clk), .en(adv), .a(mag_s4[0]), .b(mag_s4[4]), .prod(prod_s6[4]));
	bw_mul u_mul5 (.clk(clk), .en(adv), .a(mag_s4[1]), .b(mag_s4[3]), .prod(prod_s6[5]));

	always_ff @(posedge clk) begin
		if (adv) begin
			psg_s5 <= {sgn_s4[1] ^ sgn_s4[3], sgn_s4[4], sgn_s4[1] ^ sgn_s4[4],
				sgn_s4[3], 1'b0, 1'b0};
			psg_s6 <= psg_s5;
		end
	end

	// ---------------- stage 7: signed products ----------------
	logic                  v_s7;
	logic signed [SPW-1:0] sp_s7[6];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 6; k++) begin
				sp_s7[k] <= psg_s6[k] ? -{1'b0, prod_s6[k]} : {1'b0, prod_s6[k]};
			end
		end
	end

	// ---------------- stage 8: denominator and numerators ----------------
	logic                  v_s8;
	logic [DW-1:0]         den_s8;
	logic signed [NUW-1:0] nv_s8, nw_s8;
	logic signed [SPW-1:0] den_full;

	assign den_full = sp_s7[0] - sp_s7[1];

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s8 <= den_full[DW-1:0];
			nv_s8  <= {sp_s7[2][SPW-1], sp_s7[2]} - {sp_s7[3][SPW-1], sp_s7[3]};
			nw_s8  <= {sp_s7[4][SPW-1], sp_s7[4]} - {sp_s7[5][SPW-1], sp_s7[5]};
		end
	end

	// ---------------- stage 9: numerator magnitudes ----------------
	logic                  v_s9;
	logic [DW-1:0]         den_s9;
	logic [NMW-1:0]        nvm_s9, nwm_s9;
	bw_pkg::bw_side_t      side_s9;
	logic signed [NUW-1:0] nv_neg, nw_neg;

	assign nv_neg = -nv_s8;
	assign nw_neg = -nw_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s9        <= den_s8;
			nvm_s9        <= nv_s8[NUW-1] ? nv_neg[NMW-1:0] : nv_s8[NMW-1:0];
			nwm_s9        <= nw_s8[NUW-1] ? nw_neg[NMW-1:0] : nw_s8[NMW-1:0];
			side_s9.deg   <= (den_s8 == '0);
			side_s9.neg_v <= nv_s8[NUW-1];
			side_s9.neg_w <= nw_s8[NUW-1];
		end
	end

	// ---------------- divider ----------------
	logic             dq_valid;
	logic [QW-1:0]    dq_v, dq_w;
	bw_pkg::bw_side_t dq_side;

	bw_div #(.QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s9),
		.den      (den_s9),
		.num_v    (nvm_s9),
		.num_w    (nwm_s9),
		.side_in  (side_s9),
		.out_valid(dq_valid),
		.quo_v    (dq_v),
		.quo_w    (dq_w),
		.side_out (dq_side)
	);

	// ---------------- stage 10: signed quotients ----------------
	logic                 v_s10, deg_s10;
	logic signed [SW-1:0] qv_s10, qw_s10;
	logic signed [SW-1:0] qv_pos, qw_pos;

	assign qv_pos = {1'b0, dq_v};
	assign qw_pos = {1'b0, dq_w};

	always_ff @(posedge clk) begin
		if (adv) begin
			qv_s10  <= dq_side.neg_v ? -qv_pos : qv_pos;
			qw_s10  <= dq_side.neg_w ? -qw_pos : qw_pos;
			deg_s10 <= dq_side.deg;
		end
	end

	// ---------------- stage 11: first weight ----------------
	logic                 v_s11, deg_s11;
	logic signed [UW-1:0] u_s11, v_w_s11, w_w_s11;
	logic signed [UW-1:0] qv_ext, qw_ext;

	assign qv_ext = {{(UW-SW){qv_s10[SW-1]}}, qv_s10};
	assign qw_ext = {{(UW-SW){qw_s10[SW-1]}}, qw_s10};

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s11   <= ONE_W - qv_ext - qw_ext;
			v_w_s11 <= qv_ext;
			w_w_s11 <= qw_ext;
			deg_s11 <= deg_s10;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= query.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= dq_valid;
			v_s11 <= v_s10;
		end
	end

	// ---------------- saturation and output ----------------
	function automatic logic signed [WW-1:0] sat_w(input logic signed [UW-1:0] x);
		logic [UW-WW:0] hi;
		hi = x[UW-1:WW-1];
		if ((&hi) || !(|hi)) begin
			sat_w = x[WW-1:0];
		end else if (x[UW-1]) begin
			sat_w = {1'b1, {(WW-1){1'b0}}};
		end else begin
			sat_w = {1'b0, {(WW-1){1'b1}}};
		end
	endfunction

	always_comb begin
		res_d.deg = deg_s11;
		res_d.u   = deg_s11 ? '0 : sat_w(u_s11);
		res_d.v   = deg_s11 ? '0 : sat_w(v_w_s11);
		res_d.w   = deg_s11 ? '0 : sat_w(w_w_s11);
	end

	logic push, take;
	assign push = adv && v_s11;
	assign take = out_v_q && weights.ready;

	// park a new result in the skid when the output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || take) begin
			if (push) begin
				out_q <= res_d;
			end
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign weights.valid      = out_v_q;
	assign weights.weight_u   = out_q.u;
	assign weights.weight_v   = out_q.v;
	assign weights.weight_w   = out_q.w;
	assign weights.degenerate = out_q.deg;

endmodule

`default_nettype wire
